// ===== rtl/core/i2c_scl_pkg.sv =====
`default_nettype none

package i2c_scl_pkg;

    // field widths
    localparam int FREQ_W   = 21;
    localparam int CLK_W    = 14;
    localparam int CLKRF_W  = 20;
    localparam int DEN_W    = 20;
    localparam int NUM_W    = 20;
    localparam int DVD_W    = 28;
    localparam int Q_W      = 10;
    localparam int CNT_W    = 8;
    localparam int RF_W     = 7;
    localparam int ML_W     = 8;
    localparam int DK_W     = 10;
    localparam int HREC_W   = 24;

    // speed mode codes
    localparam logic [1:0] MODE_STD   = 2'd0;
    localparam logic [1:0] MODE_FAST  = 2'd1;
    localparam logic [1:0] MODE_FASTP = 2'd2;
    localparam logic [1:0] MODE_TURBO = 2'd3;

    // frequency limits and thresholds
    localparam logic [FREQ_W-1:0] FREQ_MAX     = 21'd1265800;
    localparam logic [FREQ_W-1:0] FREQ_MIN     = 21'd60300;
    localparam logic [FREQ_W-1:0] THRESH_TURBO = 21'd1000000;
    localparam logic [FREQ_W-1:0] THRESH_FASTP = 21'd400000;
    localparam logic [FREQ_W-1:0] THRESH_FAST  = 21'd100000;
    // f / 100 < 648 exactly when f < 64800
    localparam logic [FREQ_W-1:0] FIXED_FREQ   = 21'd64800;

    localparam logic [NUM_W-1:0] NANO_SCALE = 20'd1000000;
    localparam logic [CNT_W-1:0] FIXED_LOW  = 8'd255;
    localparam logic [15:0]      DEN_OFFSET = 16'd255;

    // divide by 100 as multiply by rounded-up reciprocal, exact for 21-bit values
    localparam int RECIP_SHIFT = 28;
    localparam longint unsigned Recip100 = ((64'd1 << RECIP_SHIFT) + 64'd99) / 64'd100;
    localparam int RECIP_W = 22;
    localparam logic [RECIP_W-1:0] RECIP100 = RECIP_W'(Recip100);

    // per-mode minimum low / minimum high
    localparam longint unsigned MhStd = 134, MlStd = 157;
    localparam longint unsigned MhFast = 20, MlFast = 44;
    localparam longint unsigned MhFastp = 9, MlFastp = 17;
    localparam longint unsigned MhTurbo = 5, MlTurbo = 14;

    // high = floor(low * mh / ml) as multiply by rounded-up mh/ml ratio
    localparam int HREC_SHIFT = 24;
    localparam longint unsigned HrecStd   = ((64'd1 << HREC_SHIFT) * MhStd + MlStd - 1) / MlStd;
    localparam longint unsigned HrecFast  = ((64'd1 << HREC_SHIFT) * MhFast + MlFast - 1)
                                            / MlFast;
    localparam longint unsigned HrecFastp = ((64'd1 << HREC_SHIFT) * MhFastp + MlFastp - 1)
                                            / MlFastp;
    localparam longint unsigned HrecTurbo = ((64'd1 << HREC_SHIFT) * MhTurbo + MlTurbo - 1)
                                            / MlTurbo;

    typedef struct packed {
        logic [1:0] mode;
        logic       fixed;
    } t_ctl;

    function automatic logic [RF_W-1:0] mode_rf(input logic [1:0] mode);
        logic [RF_W-1:0] v;
        case (mode)
            MODE_STD:   v = 7'd127;
            MODE_FAST:  v = 7'd58;
            MODE_FASTP: v = 7'd22;
            default:    v = 7'd22;
        endcase
        return v;
    endfunction

    function automatic logic [ML_W-1:0] mode_ml(input logic [1:0] mode);
        logic [ML_W-1:0] v;
        case (mode)
            MODE_STD:   v = ML_W'(MlStd);
            MODE_FAST:  v = ML_W'(MlFast);
            MODE_FASTP: v = ML_W'(MlFastp);
            default:    v = ML_W'(MlTurbo);
        endcase
        return v;
    endfunction

    // 3 * (mh + ml)
    function automatic logic [DK_W-1:0] mode_dk(input logic [1:0] mode);
        logic [DK_W-1:0] v;
        case (mode)
            MODE_STD:   v = DK_W'(3 * (MhStd + MlStd));
            MODE_FAST:  v = DK_W'(3 * (MhFast + MlFast));
            MODE_FASTP: v = DK_W'(3 * (MhFastp + MlFastp));
            default:    v = DK_W'(3 * (MhTurbo + MlTurbo));
        endcase
        return v;
    endfunction

    function automatic logic [HREC_W-1:0] mode_hrec(input logic [1:0] mode);
        logic [HREC_W-1:0] v;
        case (mode)
            MODE_STD:   v = HREC_W'(HrecStd);
            MODE_FAST:  v = HREC_W'(HrecFast);
            MODE_FASTP: v = HREC_W'(HrecFastp);
            default:    v = HREC_W'(HrecTurbo);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/i2c_scl_timing_calc_core.sv =====
`default_nettype none
// pipeline: one item per stage from input accept to result valid
// throughput: one item per cycle while the output is not stalled; the ten-stage restoring divider sets the depth
// every stage holds its item under back-pressure and frees as soon as the next moves
// reset: synchronous active-low, clears all stage valid bits; payload is not reset

module i2c_scl_timing_calc_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // [20:0] frequency_hz, [23:21] zero
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [23:0]      o_m_tdata    // [1:0] mode_code, [9:2] scl_high_count,
                                          // [17:10] scl_low_count, [18] high_overflow
);
    import i2c_scl_pkg::*;

    // stage map: 0 clamp/mode, 1 divide by 100, 2 products, 3 dividend,
    // 4..13 divider steps, 14 output register
    localparam int DIV_STEPS = Q_W;
    localparam int NST       = 4 + DIV_STEPS + 1;
    localparam int DIV_EXT   = DVD_W + 2;

    logic [NST-1:0] r_vld;
    logic [NST-1:0] w_adv;
    t_ctl           r_ctl [NST-1];

    logic [FREQ_W-1:0] r_fc;
    logic [CLK_W-1:0]  r_clk;
    logic [CLKRF_W-1:0] r_clkrf;
    logic [DEN_W-1:0]  r_den2;
    logic [DVD_W-1:0]  r_dvd;
    logic [DEN_W-1:0]  r_den3;
    logic [DVD_W-1:0]  r_rem [DIV_STEPS-1];
    logic [DEN_W-1:0]  r_dd  [DIV_STEPS-1];
    logic [Q_W-1:0]    r_q   [DIV_STEPS];

    logic [1:0]       r_mode_o;
    logic [CNT_W-1:0] r_high;
    logic [CNT_W-1:0] r_low;
    logic             r_ovf;

    // per-stage advance: a stage may load when it is empty or its item moves on
    always_comb begin
        w_adv[NST-1] = !r_vld[NST-1] || i_m_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_s_tready = w_adv[0];
    assign o_m_tvalid = r_vld[NST-1];
    assign o_m_tdata  = {5'd0, r_ovf, r_low, r_high, r_mode_o};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= (k == 0) ? i_s_tvalid : r_vld[(k == 0) ? 0 : k - 1];
                end
            end
        end
    end

    // stage 0: clamp, mode select, fixed-low test
    logic [FREQ_W-1:0] w_fc;
    logic [1:0]        w_mode;

    always_comb begin
        w_fc = i_s_tdata[FREQ_W-1:0];
        if (w_fc > FREQ_MAX) w_fc = FREQ_MAX;
        if (w_fc < FREQ_MIN) w_fc = FREQ_MIN;
        if (w_fc > THRESH_TURBO)      w_mode = MODE_TURBO;
        else if (w_fc > THRESH_FASTP) w_mode = MODE_FASTP;
        else if (w_fc > THRESH_FAST)  w_mode = MODE_FAST;
        else                          w_mode = MODE_STD;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_fc <= w_fc;
        end
    end

    // control fields follow their item through the stages
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_ctl[0].mode  <= w_mode;
            r_ctl[0].fixed <= (w_fc < FIXED_FREQ);
        end
        for (int k = 1; k < NST - 1; k++) begin
            if (w_adv[k]) r_ctl[k] <= r_ctl[k-1];
        end
    end

    // stage 1: clk = f / 100
    logic [42:0] w_clk_prod;
    assign w_clk_prod = 43'(r_fc) * 43'(RECIP100);

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) r_clk <= w_clk_prod[RECIP_SHIFT +: CLK_W];
    end

    // stage 2: clk * rise/fall and the divisor
    logic [20:0] w_clkrf_prod;
    logic [23:0] w_den_prod;
    logic [15:0] w_clk3;
    logic [DEN_W-1:0] w_den2;

    always_comb begin
        w_clkrf_prod = 21'(r_clk) * 21'(mode_rf(r_ctl[1].mode));
        w_den_prod   = 24'(r_clk) * 24'(mode_dk(r_ctl[1].mode));
        w_clk3       = {1'b0, r_clk, 1'b0} + 16'(r_clk);
        // on the fixed-low path 3*clk always exceeds 255
        if (r_ctl[1].fixed) w_den2 = DEN_W'(w_clk3 - DEN_OFFSET);
        else                w_den2 = w_den_prod[DEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_clkrf <= w_clkrf_prod[CLKRF_W-1:0];
            r_den2  <= w_den2;
        end
    end

    // stage 3: numerator, scaled by min-low off the fixed path
    logic [NUM_W-1:0] w_num;
    logic [DVD_W-1:0] w_dvd_prod;

    always_comb begin
        // clk * rf never reaches the scale over the clamped range
        w_num      = NANO_SCALE - r_clkrf;
        w_dvd_prod = DVD_W'(w_num) * DVD_W'(mode_ml(r_ctl[2].mode));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_dvd  <= r_ctl[2].fixed ? DVD_W'(w_num) : w_dvd_prod;
            r_den3 <= r_den2;
        end
    end

    // stages 4..13: restoring divider, one quotient bit per stage, msb first
    genvar g;
    generate
        for (g = 0; g < DIV_STEPS; g++) begin : g_div
            localparam int B = DIV_STEPS - 1 - g;
            logic [DVD_W-1:0]   w_rem_in;
            logic [DEN_W-1:0]   w_den_in;
            logic [Q_W-1:0]     w_q_in;
            logic [DIV_EXT-1:0] w_sh;
            logic               w_ge;
            logic [DVD_W-1:0]   w_rem_out;

            if (g == 0) begin : g_src0
                assign w_rem_in = r_dvd;
                assign w_den_in = r_den3;
                assign w_q_in   = '0;
            end else begin : g_srcn
                assign w_rem_in = r_rem[g-1];
                assign w_den_in = r_dd[g-1];
                assign w_q_in   = r_q[g-1];
            end

            assign w_sh      = DIV_EXT'(w_den_in) << B;
            assign w_ge      = DIV_EXT'(w_rem_in) >= w_sh;
            assign w_rem_out = w_ge ? DVD_W'(DIV_EXT'(w_rem_in) - w_sh) : w_rem_in;

            always_ff @(posedge i_clk) begin
                if (w_adv[4+g]) begin
                    r_q[g] <= w_q_in | (Q_W'(w_ge) << B);
                end
            end

            if (g < DIV_STEPS - 1) begin : g_pass
                always_ff @(posedge i_clk) begin
                    if (w_adv[4+g]) begin
                        r_rem[g] <= w_rem_out;
                        r_dd[g]  <= w_den_in;
                    end
                end
            end
        end
    endgenerate

    // stage 14: counts and overflow flag into the output register
    logic [Q_W-1:0] w_q;
    logic [31:0]    w_hprod;
    t_ctl           w_ctl;

    always_comb begin
        w_q     = r_q[DIV_STEPS-1];
        w_ctl   = r_ctl[NST-2];
        w_hprod = 32'(w_q[CNT_W-1:0]) * 32'(mode_hrec(w_ctl.mode));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[NST-1]) begin
            r_mode_o <= w_ctl.mode;
            if (w_ctl.fixed) begin
                // quotient is the high count; keep its low byte
                r_high <= w_q[CNT_W-1:0];
                r_low  <= FIXED_LOW;
                r_ovf  <= (w_q > Q_W'(FIXED_LOW));
            end else begin
                r_high <= w_hprod[HREC_SHIFT +: CNT_W];
                r_low  <= w_q[CNT_W-1:0];
                r_ovf  <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/tb_i2c_scl_timing_calc_core.sv =====
`timescale 1ns / 1ps

module tb_i2c_scl_timing_calc_core;

    import i2c_scl_pkg::*;

    // clock period and run control
    localparam int CLK_PERIOD_NS   = 20;
    localparam int RESET_CYCLES    = 8;
    localparam int RANDOM_BLOCKS   = 5;
    localparam int BLOCK_ITEMS     = 150;
    localparam int QUIET_BLOCK     = 1;      // block run with no random gaps or stalls on either side
    localparam int HOLD_AT_RESULT  = 300;    // result count that starts the long receiver hold
    localparam int HOLD_CYCLES     = 150;
    localparam int DRAIN_CYCLES    = 40;     // pipeline is 15 deep
    localparam int STUCK_LIMIT     = 2000;   // cycles with nothing accepted on either side

    // timing constants of the calculation
    localparam longint unsigned FIXED_CLK_LIMIT = 648;
    localparam longint unsigned OSC_MULT        = 3;

    // one result item, unpacked
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] high_cnt;
        logic [7:0] low_cnt;
        logic       high_ovf;
    } scl_setting_t;

    // one row of the directed table
    typedef struct {
        logic [FREQ_W-1:0] freq;
        bit                typed;   // expectation written out by hand
        scl_setting_t      want;
    } freq_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [23:0] s_tdata   = '0;     // [20:0] frequency_hz, [23:21] zero
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;            // [1:0] mode_code, [9:2] scl_high_count,
                                     // [17:10] scl_low_count, [18] high_overflow

    scl_setting_t pending_settings[$];   // settings still owed by the block, oldest first
    freq_row_t    freq_rows[$];
    int           err_cnt      = 0;
    int           results_seen = 0;
    bit           idle_on      = 1'b1;   // random gaps and stalls allowed

    i2c_scl_timing_calc_core u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    // free-running clock
    initial begin
        forever begin
            #(CLK_PERIOD_NS / 2) clk = ~clk;
        end
    end

    // clamp, pick the speed mode, then derive the scl low and high counts
    function automatic scl_setting_t calc_scl_setting(input logic [FREQ_W-1:0] freq);
        longint unsigned f, bus_clk, min_low, min_high, rise_fall;
        longint unsigned num, den, low, high;
        scl_setting_t    s;
        f = freq;
        if (f > FREQ_MAX) f = FREQ_MAX;
        if (f < FREQ_MIN) f = FREQ_MIN;
        bus_clk = f / 100;
        if (f > THRESH_TURBO) begin
            s.mode = MODE_TURBO; min_low = 14;  min_high = 5;   rise_fall = 22;
        end else if (f > THRESH_FASTP) begin
            s.mode = MODE_FASTP; min_low = 17;  min_high = 9;   rise_fall = 22;
        end else if (f > THRESH_FAST) begin
            s.mode = MODE_FAST;  min_low = 44;  min_high = 20;  rise_fall = 58;
        end else begin
            s.mode = MODE_STD;   min_low = 157; min_high = 134; rise_fall = 127;
        end
        num = (bus_clk * rise_fall < NANO_SCALE) ? (NANO_SCALE - bus_clk * rise_fall) : 0;
        if (bus_clk < FIXED_CLK_LIMIT) begin
            // slow bus: low count pinned, high count absorbs the rest
            low  = FIXED_LOW;
            den  = OSC_MULT * bus_clk;
            den  = (den > low) ? (den - low) : 1;
            high = num / den;
        end else begin
            den  = OSC_MULT * bus_clk * (min_high + min_low);
            low  = (den != 0) ? (num * min_low) / den : 0;
            high = low * min_high / min_low;
        end
        s.high_cnt = high[7:0];
        s.low_cnt  = low[7:0];
        s.high_ovf = (high > 255);
        return s;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        err_cnt++;
    endtask

    task automatic add_row(input logic [FREQ_W-1:0] freq, input bit typed,
                           input logic [1:0] mode, input int high, input int low,
                           input bit ovf);
        freq_row_t r;
        r.freq          = freq;
        r.typed         = typed;
        r.want.mode     = mode;
        r.want.high_cnt = high[7:0];
        r.want.low_cnt  = low[7:0];
        r.want.high_ovf = ovf;
        freq_rows.push_back(r);
    endtask

    // sender gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random frequency, weighted toward the mode thresholds and the fixed-low range
    function automatic logic [FREQ_W-1:0] pick_freq();
        int          r;
        int unsigned edge_hz;
        r = $urandom_range(0, 99);
        if (r < 12) return FREQ_W'($urandom());
        if (r < 27) return FREQ_W'($urandom_range(60300, 64900));
        if (r < 50) begin
            case ($urandom_range(0, 5))
                0:       edge_hz = FREQ_MIN;
                1:       edge_hz = FIXED_FREQ;
                2:       edge_hz = THRESH_FAST;
                3:       edge_hz = THRESH_FASTP;
                4:       edge_hz = THRESH_TURBO;
                default: edge_hz = FREQ_MAX;
            endcase
            return FREQ_W'(edge_hz - 300 + $urandom_range(0, 600));
        end
        return FREQ_W'($urandom_range(60300, 1265800));
    endfunction

    // offer one frequency item and wait until the block takes it
    task automatic drive_item(input logic [FREQ_W-1:0] freq, input scl_setting_t want);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, freq};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        pending_settings.push_back(want);
    endtask

    // result side: random stalls, one long hold-off, check every accepted item
    initial begin
        int           stall_left;
        int           r;
        bit           hold_done;
        scl_setting_t got;
        scl_setting_t want;
        stall_left = 0;
        hold_done  = 1'b0;
        @(posedge clk);
        forever begin
            if (!hold_done && results_seen >= HOLD_AT_RESULT) begin
                // hold off long enough for the pipeline to fill and stall the input
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (!idle_on || r < 60) begin
                    m_tready <= 1'b1;
                end else if (r < 92) begin
                    stall_left = $urandom_range(0, 3);
                    m_tready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(15, 60);
                    m_tready <= 1'b0;
                end
            end
            @(posedge clk);
            if (m_tready && m_tvalid) begin
                got.mode     = m_tdata[1:0];
                got.high_cnt = m_tdata[9:2];
                got.low_cnt  = m_tdata[17:10];
                got.high_ovf = m_tdata[18];
                if (pending_settings.size() == 0) begin
                    report_mismatch("unexpected item, mode", got.mode, -1);
                end else begin
                    want = pending_settings.pop_front();
                    if (got.mode !== want.mode)
                        report_mismatch("mode_code", got.mode, want.mode);
                    if (got.high_cnt !== want.high_cnt)
                        report_mismatch("scl_high_count", got.high_cnt, want.high_cnt);
                    if (got.low_cnt !== want.low_cnt)
                        report_mismatch("scl_low_count", got.low_cnt, want.low_cnt);
                    if (got.high_ovf !== want.high_ovf)
                        report_mismatch("high_overflow", got.high_ovf, want.high_ovf);
                end
                results_seen++;
            end
        end
    end

    // watchdog: too long with no item moving on either side
    initial begin
        int stuck_cnt;
        stuck_cnt = 0;
        while (stuck_cnt < STUCK_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tready && m_tvalid))
                stuck_cnt = 0;
            else
                stuck_cnt++;
        end
        $display("watchdog: nothing accepted for %0d cycles", STUCK_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // stimulus
    initial begin
        freq_row_t    row;
        scl_setting_t want;
        logic [FREQ_W-1:0] freq;

        // below the clamp and the clamp floor itself: fixed-low path with high overflow
        add_row(21'd0,       1, MODE_STD,   82,  255, 1);
        add_row(21'd1,       1, MODE_STD,   82,  255, 1);
        add_row(21'd60299,   1, MODE_STD,   82,  255, 1);
        add_row(FREQ_MIN,    1, MODE_STD,   82,  255, 1);
        add_row(21'd60301,   0, MODE_STD,   0,   0,   0);
        // edge of the fixed-low range
        add_row(21'd64799,   0, MODE_STD,   0,   0,   0);
        add_row(FIXED_FREQ,  0, MODE_STD,   0,   0,   0);
        add_row(21'd64899,   0, MODE_STD,   0,   0,   0);
        // mode thresholds
        add_row(21'd99999,   0, MODE_STD,   0,   0,   0);
        add_row(THRESH_FAST, 0, MODE_STD,   0,   0,   0);
        add_row(21'd100001,  0, MODE_STD,   0,   0,   0);
        add_row(21'd100099,  0, MODE_STD,   0,   0,   0);
        add_row(21'd399999,  0, MODE_STD,   0,   0,   0);
        add_row(THRESH_FASTP, 0, MODE_STD,  0,   0,   0);
        add_row(21'd400001,  0, MODE_STD,   0,   0,   0);
        add_row(21'd999999,  0, MODE_STD,   0,   0,   0);
        add_row(THRESH_TURBO, 0, MODE_STD,  0,   0,   0);
        add_row(21'd1000001, 0, MODE_STD,   0,   0,   0);
        // clamp ceiling and above
        add_row(21'd1265799, 0, MODE_STD,   0,   0,   0);
        add_row(FREQ_MAX,    1, MODE_TURBO, 5,   14,  0);
        add_row(21'd1265801, 1, MODE_TURBO, 5,   14,  0);
        add_row(21'h1FFFFF,  1, MODE_TURBO, 5,   14,  0);
        // alternating bit patterns and a single set bit
        add_row(21'h155555,  1, MODE_TURBO, 5,   14,  0);
        add_row(21'h0AAAAA,  0, MODE_STD,   0,   0,   0);
        add_row(21'h100000,  0, MODE_STD,   0,   0,   0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (freq_rows[i]) begin
            row  = freq_rows[i];
            want = row.typed ? row.want : calc_scl_setting(row.freq);
            drive_item(row.freq, want);
        end

        // random blocks, one of them with no random gaps or stalls
        for (int b = 0; b < RANDOM_BLOCKS; b++) begin
            idle_on = (b != QUIET_BLOCK);
            for (int k = 0; k < BLOCK_ITEMS; k++) begin
                freq = pick_freq();
                drive_item(freq, calc_scl_setting(freq));
            end
        end
        idle_on  = 1'b1;
        s_tvalid <= 1'b0;

        // drain, then give any stray item time to show up
        wait (pending_settings.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_settings.size() != 0)
            report_mismatch("items never returned", pending_settings.size(), 0);

        if (err_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
